@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the joystick axis calibration block.
// Depends on nothing; NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/core/jacm_pkg.sv @@
// Shared constants and types for the joystick axis calibration and mapping block.
// Depends on nothing; used by joystick_axis_calibrate_map.
package jacm_pkg;

	// Default configuration of the block.
	localparam int DEFAULT_STICKS      = 2;
	localparam int DEFAULT_CAL_SAMPLES = 64;
	localparam int DEFAULT_SAMPLE_BITS = 12;

	// Output range is -OUT_HIGH..OUT_HIGH; OUT_HIGH is 2^15 - 4.
	localparam int POS_BITS = 16;
	localparam int OUT_HIGH = 32764;

	// The largest quotient is 2 * OUT_HIGH, which needs 16 bits; the quotient is 17 bits wide.
	localparam int QUO_BITS = 17;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 12;
	localparam int DZ_BITS        = 12;
	localparam int DZ_RESET       = 64;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_MAPPING = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_X    = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_Y    = 2'd3;

	// Request opcodes.
	localparam logic OP_NORMAL      = 1'b0;
	localparam logic OP_CALIBRATION = 1'b1;

	typedef logic signed [POS_BITS-1:0] pos_t;

endpackage

@@ rtl/core/joystick_axis_calibrate_map.sv @@
// Top level of the joystick axis calibration and mapping block.
// Depends on jacm_pkg and assert_macros.svh.
//
// Each request carries one X/Y sample pair for one stick. A normal request widens
// that stick's per-axis bounds and maps both axes to -32764..32764, either with a
// deadzone and two slopes around the neutral point or by linear interpolation
// between the bounds, then applies the per-axis inversion. A calibration request
// adds the pair to a per-axis sum; every CAL_SAMPLES-th one sets neutral to the
// truncated average and flags calibration_done. One request is worked on at a time.
// A normal request, and a calibration request that completes the average, raise
// out_valid when the result register is free, after a state update, then per axis
// a setup step, the shared bit-serial restoring divider and a write-back step, and
// then the load of the result register. Any other calibration request, or one for a
// stick index out of range, goes from the state update straight to that load. The
// next request is taken in the cycle after the result register is loaded. The
// divider, shared by both axes, forms one quotient bit per cycle. A new request is
// taken while the previous result still waits in the output register.
module joystick_axis_calibrate_map #(
	parameter int STICKS      = jacm_pkg::DEFAULT_STICKS,
	parameter int CAL_SAMPLES = jacm_pkg::DEFAULT_CAL_SAMPLES,
	parameter int SAMPLE_BITS = jacm_pkg::DEFAULT_SAMPLE_BITS,
	localparam int SIW = (STICKS > 1) ? $clog2(STICKS) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [jacm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [jacm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// Sample request channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 opcode,
	input  logic [SIW-1:0]                       stick_index,
	input  logic [SAMPLE_BITS-1:0]               x_sample,
	input  logic [SAMPLE_BITS-1:0]               y_sample,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output jacm_pkg::pos_t                       x_position,
	output jacm_pkg::pos_t                       y_position,
	output logic                                 calibration_done
);

	`include "assert_macros.svh"

	localparam int SB    = SAMPLE_BITS;
	localparam int CNTW  = $clog2(CAL_SAMPLES);
	localparam int SUMW  = SB + $clog2(CAL_SAMPLES);
	localparam int CALW  = $clog2(CAL_SAMPLES + 1);
	localparam int DVW   = (SB > CALW) ? SB : CALW;
	localparam int QW    = jacm_pkg::QUO_BITS;
	localparam int NW    = DVW + QW;
	localparam int QCW   = $clog2(QW);
	localparam int MW    = (SB > jacm_pkg::DZ_BITS) ? SB : jacm_pkg::DZ_BITS;
	localparam int PB    = jacm_pkg::POS_BITS;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic       axis_q;
	logic [QCW-1:0] step_q;
	logic       out_valid_q;

	// Configuration registers.
	logic                          cal_map_q;
	logic [jacm_pkg::DZ_BITS-1:0]  dz_q;
	logic                          inv_x_q;
	logic                          inv_y_q;

	// Per-stick state.
	logic [SB-1:0]   lo_q  [STICKS][2];
	logic [SB-1:0]   hi_q  [STICKS][2];
	logic [SB-1:0]   mid_q [STICKS][2];
	logic [SUMW-1:0] sum_q [STICKS][2];
	logic [CNTW-1:0] cnt_q [STICKS];

	// Request payload and working registers.
	logic            op_q;
	logic [SIW-1:0]  stick_q;
	logic [SB-1:0]   smp_q [2];
	logic [DVW-1:0]  rem_q;
	logic [QW-1:0]   quo_q;
	logic [DVW-1:0]  div_d_q;
	logic            zero_q;
	logic            neg_q;
	jacm_pkg::pos_t  pos_q [2];
	logic            done_q;
	jacm_pkg::pos_t  x_q;
	jacm_pkg::pos_t  y_q;
	logic            done_out_q;

	logic in_fire;
	logic out_load;
	logic stick_ok;
	logic cal_last;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign stick_ok  = (32'(stick_q) < STICKS);
	assign cal_last  = (cnt_q[stick_q] == CNTW'(CAL_SAMPLES - 1));

	assign out_valid        = out_valid_q;
	assign x_position       = x_q;
	assign y_position       = y_q;
	assign calibration_done = done_out_q;

	// Divider setup for the current axis: zero detection, magnitude and divisor.
	logic [SB-1:0]        s_c, lo_c, hi_c, mid_c;
	logic signed [SB:0]   d_c;
	logic [SB:0]          dneg_c;
	logic [SB-1:0]        dmag_c;
	logic [SB-1:0]        m_c;
	logic [DVW-1:0]       den_c;
	logic [NW-1:0]        nm_c;
	logic [NW-1:0]        num_c;
	logic                 zero_c;

	always_comb begin
		s_c    = smp_q[axis_q];
		lo_c   = lo_q[stick_q][axis_q];
		hi_c   = hi_q[stick_q][axis_q];
		mid_c  = mid_q[stick_q][axis_q];
		d_c    = $signed({1'b0, s_c}) - $signed({1'b0, mid_c});
		dneg_c = -d_c;
		dmag_c = d_c[SB] ? dneg_c[SB-1:0] : d_c[SB-1:0];
		if (cal_map_q) begin
			m_c    = dmag_c;
			den_c  = DVW'(d_c[SB] ? (mid_c - lo_c) : (hi_c - mid_c));
			zero_c = (hi_c == lo_c) || (d_c == '0) || (MW'(dmag_c) < MW'(dz_q));
		end else begin
			m_c    = s_c - lo_c;
			den_c  = DVW'(hi_c - lo_c);
			zero_c = (hi_c == lo_c);
		end
		nm_c = NW'(m_c);
		if (op_q == jacm_pkg::OP_CALIBRATION) begin
			num_c = NW'(sum_q[stick_q][axis_q]);
			den_c = DVW'(CAL_SAMPLES);
		end else if (cal_map_q) begin
			// Times OUT_HIGH, which is 2^15 - 4.
			num_c = (nm_c << 15) - (nm_c << 2);
		end else begin
			// Times the full span 2 * OUT_HIGH, which is 2^16 - 8.
			num_c = (nm_c << 16) - (nm_c << 3);
		end
	end

	// One restoring division step: one quotient bit per cycle.
	logic [DVW:0]   trial_c;
	logic           ge_c;
	logic [DVW:0]   diff_c;

	always_comb begin
		trial_c = {rem_q, quo_q[QW-1]};
		diff_c  = trial_c - {1'b0, div_d_q};
		ge_c    = (trial_c >= {1'b0, div_d_q});
	end

	// Final position of the current axis from the quotient.
	logic [QW:0]     lin_c;
	logic [PB-1:0]   mag_c;
	jacm_pkg::pos_t  val_c;
	jacm_pkg::pos_t  fin_c;
	logic            inv_c;

	always_comb begin
		lin_c = {1'b0, quo_q} - (QW + 1)'(jacm_pkg::OUT_HIGH);
		mag_c = quo_q[PB-1:0];
		if (zero_q) begin
			val_c = '0;
		end else if (cal_map_q) begin
			val_c = neg_q ? -$signed(mag_c) : $signed(mag_c);
		end else begin
			val_c = $signed(lin_c[PB-1:0]);
		end
		inv_c = axis_q ? inv_y_q : inv_x_q;
		fin_c = inv_c ? -val_c : val_c;
	end

	// Sequencer, configuration and per-stick state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			cal_map_q   <= 1'b1;
			dz_q        <= jacm_pkg::DZ_BITS'(jacm_pkg::DZ_RESET);
			inv_x_q     <= 1'b0;
			inv_y_q     <= 1'b0;
			for (int i = 0; i < STICKS; i++) begin
				for (int a = 0; a < 2; a++) begin
					lo_q[i][a]  <= '1;
					hi_q[i][a]  <= '0;
					mid_q[i][a] <= '0;
					sum_q[i][a] <= '0;
				end
				cnt_q[i] <= '0;
			end
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				case (cfg_index)
					jacm_pkg::REG_CAL_MAPPING: cal_map_q <= cfg_data[0];
					jacm_pkg::REG_DEADZONE:    dz_q      <= cfg_data[jacm_pkg::DZ_BITS-1:0];
					jacm_pkg::REG_INVERT_X:    inv_x_q   <= cfg_data[0];
					jacm_pkg::REG_INVERT_Y:    inv_y_q   <= cfg_data[0];
					default: ;
				endcase
			end

			// Result register handshake.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						axis_q  <= 1'b0;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!stick_ok) begin
						state_q <= S_DONE;
					end else if (op_q == jacm_pkg::OP_CALIBRATION) begin
						for (int a = 0; a < 2; a++) begin
							sum_q[stick_q][a] <= sum_q[stick_q][a] + SUMW'(smp_q[a]);
						end
						if (cal_last) begin
							state_q <= S_PREP;
						end else begin
							cnt_q[stick_q] <= cnt_q[stick_q] + 1'b1;
							state_q        <= S_DONE;
						end
					end else begin
						for (int a = 0; a < 2; a++) begin
							if (smp_q[a] > hi_q[stick_q][a]) hi_q[stick_q][a] <= smp_q[a];
							if (smp_q[a] < lo_q[stick_q][a]) lo_q[stick_q][a] <= smp_q[a];
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					step_q  <= QCW'(QW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_POST;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				S_POST: begin
					if (op_q == jacm_pkg::OP_CALIBRATION) begin
						mid_q[stick_q][axis_q] <= quo_q[SB-1:0];
						sum_q[stick_q][axis_q] <= '0;
					end
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_PREP;
					end else begin
						if (op_q == jacm_pkg::OP_CALIBRATION) cnt_q[stick_q] <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload and divider datapath.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= opcode;
			stick_q  <= stick_index;
			smp_q[0] <= x_sample;
			smp_q[1] <= y_sample;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			done_q   <= 1'b0;
		end
		if (state_q == S_PREP) begin
			rem_q   <= num_c[NW-1:QW];
			quo_q   <= num_c[QW-1:0];
			div_d_q <= den_c;
			zero_q  <= (op_q == jacm_pkg::OP_NORMAL) && zero_c;
			neg_q   <= d_c[SB];
		end
		if (state_q == S_DIV) begin
			rem_q <= ge_c ? diff_c[DVW-1:0] : trial_c[DVW-1:0];
			quo_q <= {quo_q[QW-2:0], ge_c};
		end
		if (state_q == S_POST) begin
			if (op_q == jacm_pkg::OP_NORMAL) begin
				pos_q[axis_q] <= fin_c;
			end else if (axis_q) begin
				done_q <= 1'b1;
			end
		end
		if (out_load) begin
			x_q        <= pos_q[0];
			y_q        <= pos_q[1];
			done_out_q <= done_q;
		end
	end

	// Only one request is in the sequencer at a time.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "request accepted while busy")
	// A completed calibration never reports a position.
	`ASSERT_SAME(a_cal_zero_pos, clk, arst_n, out_valid && calibration_done, (x_position == '0) && (y_position == '0), "calibration result with nonzero position")
	// The partial remainder stays below the divisor while a real quotient is formed.
	`ASSERT_SAME(a_rem_below_div, clk, arst_n, (state_q == S_DIV) && !zero_q && (div_d_q != '0), rem_q < div_d_q, "divider remainder overflow")

endmodule
